>>> design/dics_pkg.sv
// dics_pkg: shared widths, constants and codes for the compartment step core
// used by dics_serial_mul, dics_serial_div and dual_input_compartment_step_core
// no dependencies
package dics_pkg;

    localparam int DICS_WORD_W    = 32;
    localparam int DICS_MIN_W     = 16;
    localparam int DICS_STAT_W    = 2;
    localparam int DICS_SUM_W     = 64;
    localparam int DICS_PROD_W    = 96;
    localparam int DICS_FRAC_SH   = 40;
    localparam int DICS_DENOM_W   = 65;
    localparam int DICS_NUMER_W   = 97;
    localparam int DICS_DIVN_W    = 99;
    localparam int DICS_DIVD_W    = 66;
    localparam int DICS_QUO_W     = 32;
    localparam int DICS_IDX_W     = 2;

    // 1.0 in the scale of the denominator
    localparam logic [DICS_DENOM_W-1:0] DICS_UNITY = DICS_DENOM_W'(1) << DICS_FRAC_SH;

    localparam logic [DICS_WORD_W-1:0] DICS_ARTERIAL_RST = 32'd19635;
    localparam logic [DICS_WORD_W-1:0] DICS_VENOUS_RST   = 32'd300375;
    localparam logic [DICS_WORD_W-1:0] DICS_OUTFLOW_RST  = 32'd1205712;
    localparam logic [DICS_MIN_W-1:0]  DICS_MIN_INT_RST  = 16'd1;

    localparam logic [DICS_IDX_W-1:0] DICS_IDX_ARTERIAL = 2'd0;
    localparam logic [DICS_IDX_W-1:0] DICS_IDX_VENOUS   = 2'd1;
    localparam logic [DICS_IDX_W-1:0] DICS_IDX_OUTFLOW  = 2'd2;
    localparam logic [DICS_IDX_W-1:0] DICS_IDX_MIN_INT  = 2'd3;

    localparam logic [DICS_STAT_W-1:0] DICS_ST_OK       = 2'd0;
    localparam logic [DICS_STAT_W-1:0] DICS_ST_INTERVAL = 2'd1;
    localparam logic [DICS_STAT_W-1:0] DICS_ST_SAT      = 2'd2;

endpackage

>>> design/dics_serial_mul.sv
// dics_serial_mul: shift-and-add multiplier, one multiplier bit per cycle
// depends on dics_pkg for default widths
module dics_serial_mul
    import dics_pkg::*;
#(
    parameter int MC_W = DICS_WORD_W,
    parameter int MR_W = DICS_WORD_W
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [MC_W-1:0]      mcand,
    input  logic [MR_W-1:0]      mplier,
    output logic                 done,
    output logic [MC_W+MR_W-1:0] product
);

    localparam int P_W   = MC_W + MR_W;
    localparam int CNT_W = $clog2(MR_W + 1);

    logic [P_W-1:0]   acc_reg, acc_next;
    logic [MC_W-1:0]  mc_reg, mc_next;
    logic [MR_W-1:0]  mr_reg, mr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [MC_W:0]    sum;

    assign sum = {1'b0, acc_reg[P_W-1:MR_W]} + {1'b0, {MC_W{mr_reg[0]}} & mc_reg};

    always_comb begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mr_next   = mr_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next = '0;
            mc_next  = mcand;
            mr_next  = mplier;
            cnt_next = CNT_W'(MR_W);
            run_next = 1'b1;
        end else if (run_reg) begin
            acc_next = {sum, acc_reg[MR_W-1:1]};
            mr_next  = mr_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mr_reg  <= mr_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

>>> design/dics_serial_div.sv
// dics_serial_div: restoring divider, one quotient bit per cycle
// first step flags a quotient that does not fit; depends on dics_pkg
module dics_serial_div
    import dics_pkg::*;
#(
    parameter int NUM_W = DICS_DIVN_W,
    parameter int DEN_W = DICS_DIVD_W,
    parameter int QUO_W = DICS_QUO_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic             ovf,
    output logic [QUO_W-1:0] quo
);

    localparam int SH_W  = DEN_W + QUO_W;
    localparam int CNT_W = $clog2(QUO_W + 2);

    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [SH_W-1:0]  dsh_reg, dsh_next;
    logic [QUO_W-1:0] q_reg, q_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic             ge;

    assign ge = rem_reg >= NUM_W'(dsh_reg);

    always_comb begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = numer;
            dsh_next = {denom, {QUO_W{1'b0}}};
            q_next   = '0;
            ovf_next = 1'b0;
            cnt_next = CNT_W'(QUO_W + 1);
            run_next = 1'b1;
        end else if (run_reg) begin
            if (ge) begin
                rem_next = rem_reg - NUM_W'(dsh_reg);
            end
            if (cnt_reg == CNT_W'(QUO_W + 1)) begin
                ovf_next = ge;
            end else begin
                q_next = {q_reg[QUO_W-2:0], ge};
            end
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    assign done = done_reg;
    assign ovf  = ovf_reg;
    assign quo  = q_reg;

endmodule

>>> design/dual_input_compartment_step_core.sv
// dual_input_compartment_step_core: backward euler step of a dual-input compartment
// two serial multiply passes and a serial divide; first or rejected samples skip them
// new samples are taken only in idle, after the last result is in the output register
// reset: aresetn synchronous active low, restores rate registers and clears the state
// depends on dics_pkg, dics_serial_mul, dics_serial_div
module dual_input_compartment_step_core
    import dics_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [95:0]            s_tdata,   // sample_time, arterial_level, venous_level
    input  logic                   s_tuser,   // first_sample
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [63:0]            m_tdata,   // result_time, tissue_level
    output logic [DICS_STAT_W-1:0] m_tuser,   // status
    input  logic                   cfg_we,
    input  logic [DICS_IDX_W-1:0]  cfg_index,
    input  logic [DICS_WORD_W-1:0] cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_MUL1  = 4'd2;
    localparam logic [3:0] S_SUM   = 4'd3;
    localparam logic [3:0] S_MUL2  = 4'd4;
    localparam logic [3:0] S_NUM   = 4'd5;
    localparam logic [3:0] S_DIVST = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    localparam int W = DICS_WORD_W;

    logic [3:0]             state_reg, state_next;
    logic [W-1:0]           art_rate_reg, art_rate_next;
    logic [W-1:0]           ven_rate_reg, ven_rate_next;
    logic [W-1:0]           out_rate_reg, out_rate_next;
    logic [DICS_MIN_W-1:0]  min_int_reg, min_int_next;
    logic [W-1:0]           last_time_reg, last_time_next;
    logic [W-1:0]           last_level_reg, last_level_next;
    logic                   m_valid_reg, m_valid_next;

    logic                   first_reg, first_next;
    logic [W-1:0]           t_reg, t_next;
    logic [W-1:0]           a_reg, a_next;
    logic [W-1:0]           v_reg, v_next;
    logic [W-1:0]           dt_reg, dt_next;
    logic                   sn_reg, sn_next;
    logic [DICS_DENOM_W-1:0] den_reg, den_next;
    logic [DICS_NUMER_W-1:0] num_reg, num_next;
    logic                   nn_reg, nn_next;
    logic [W-1:0]           res_time_reg, res_time_next;
    logic [W-1:0]           res_level_reg, res_level_next;
    logic [DICS_STAT_W-1:0] res_stat_reg, res_stat_next;
    logic [W-1:0]           m_time_reg, m_time_next;
    logic [W-1:0]           m_level_reg, m_level_next;
    logic [DICS_STAT_W-1:0] m_stat_reg, m_stat_next;

    logic [W-1:0]            am, vm, cm, dt_full;
    logic                    an, vn, cn, bad;
    logic [DICS_SUM_W-1:0]   p_art, p_ven, p_out, s_mag;
    logic [DICS_PROD_W-1:0]  p_dt;
    logic                    s_neg;
    logic [DICS_NUMER_W-1:0] c_sh, d_sh, num_mag;
    logic                    num_neg;
    logic [DICS_DIVN_W-1:0]  div_n;
    logic [DICS_DIVD_W-1:0]  div_d;
    logic                    done_art, done_ven, done_out, done_dt, done_div;
    logic                    div_ovf;
    logic [DICS_QUO_W-1:0]   quo;
    logic                    start1, start2, start_div;
    logic [W-1:0]            fin_level;
    logic [DICS_STAT_W-1:0]  fin_stat;

    assign an = a_reg[W-1];
    assign vn = v_reg[W-1];
    assign cn = last_level_reg[W-1];
    assign am = an ? (~a_reg + 1'b1) : a_reg;
    assign vm = vn ? (~v_reg + 1'b1) : v_reg;
    assign cm = cn ? (~last_level_reg + 1'b1) : last_level_reg;

    assign dt_full = t_reg - last_time_reg;
    assign bad     = (t_reg < last_time_reg) || (dt_full < W'(min_int_reg));

    // sign-magnitude sum of the two inflow terms
    always_comb begin
        if (an == vn) begin
            s_mag = p_art + p_ven;
            s_neg = an;
        end else if (p_art >= p_ven) begin
            s_mag = p_art - p_ven;
            s_neg = an;
        end else begin
            s_mag = p_ven - p_art;
            s_neg = vn;
        end
    end

    assign c_sh = DICS_NUMER_W'({cm, {DICS_FRAC_SH{1'b0}}});
    assign d_sh = DICS_NUMER_W'(p_dt);

    always_comb begin
        if (cn == sn_reg) begin
            num_mag = c_sh + d_sh;
            num_neg = cn;
        end else if (c_sh >= d_sh) begin
            num_mag = c_sh - d_sh;
            num_neg = cn;
        end else begin
            num_mag = d_sh - c_sh;
            num_neg = sn_reg;
        end
    end

    // rounding to nearest: (2|num| + den) / (2 den)
    assign div_n = DICS_DIVN_W'({num_reg, 1'b0}) + DICS_DIVN_W'(den_reg);
    assign div_d = {den_reg, 1'b0};

    always_comb begin
        fin_stat = DICS_ST_OK;
        if (nn_reg) begin
            if (div_ovf || (quo > 32'h8000_0000)) begin
                fin_level = 32'h8000_0000;
                fin_stat  = DICS_ST_SAT;
            end else begin
                fin_level = ~quo + 1'b1;
            end
        end else begin
            if (div_ovf || quo[DICS_QUO_W-1]) begin
                fin_level = 32'h7FFF_FFFF;
                fin_stat  = DICS_ST_SAT;
            end else begin
                fin_level = quo;
            end
        end
    end

    assign start1    = (state_reg == S_CHECK) && !first_reg && !bad;
    assign start2    = (state_reg == S_SUM);
    assign start_div = (state_reg == S_DIVST);

    dics_serial_mul #(.MC_W(W), .MR_W(W)) u_mul_art (
        .aclk(aclk), .aresetn(aresetn), .start(start1),
        .mcand(art_rate_reg), .mplier(am), .done(done_art), .product(p_art)
    );

    dics_serial_mul #(.MC_W(W), .MR_W(W)) u_mul_ven (
        .aclk(aclk), .aresetn(aresetn), .start(start1),
        .mcand(ven_rate_reg), .mplier(vm), .done(done_ven), .product(p_ven)
    );

    dics_serial_mul #(.MC_W(W), .MR_W(W)) u_mul_out (
        .aclk(aclk), .aresetn(aresetn), .start(start1),
        .mcand(out_rate_reg), .mplier(dt_full), .done(done_out), .product(p_out)
    );

    dics_serial_mul #(.MC_W(DICS_SUM_W), .MR_W(W)) u_mul_dt (
        .aclk(aclk), .aresetn(aresetn), .start(start2),
        .mcand(s_mag), .mplier(dt_reg), .done(done_dt), .product(p_dt)
    );

    dics_serial_div #(.NUM_W(DICS_DIVN_W), .DEN_W(DICS_DIVD_W), .QUO_W(DICS_QUO_W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(start_div),
        .numer(div_n), .denom(div_d), .done(done_div), .ovf(div_ovf), .quo(quo)
    );

    always_comb begin
        state_next      = state_reg;
        art_rate_next   = art_rate_reg;
        ven_rate_next   = ven_rate_reg;
        out_rate_next   = out_rate_reg;
        min_int_next    = min_int_reg;
        last_time_next  = last_time_reg;
        last_level_next = last_level_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        first_next      = first_reg;
        t_next          = t_reg;
        a_next          = a_reg;
        v_next          = v_reg;
        dt_next         = dt_reg;
        sn_next         = sn_reg;
        den_next        = den_reg;
        num_next        = num_reg;
        nn_next         = nn_reg;
        res_time_next   = res_time_reg;
        res_level_next  = res_level_reg;
        res_stat_next   = res_stat_reg;
        m_time_next     = m_time_reg;
        m_level_next    = m_level_reg;
        m_stat_next     = m_stat_reg;

        if (cfg_we) begin
            unique case (cfg_index)
                DICS_IDX_ARTERIAL: art_rate_next = cfg_data;
                DICS_IDX_VENOUS:   ven_rate_next = cfg_data;
                DICS_IDX_OUTFLOW:  out_rate_next = cfg_data;
                DICS_IDX_MIN_INT:  min_int_next  = cfg_data[DICS_MIN_W-1:0];
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    first_next = s_tuser;
                    t_next     = s_tdata[31:0];
                    a_next     = s_tdata[63:32];
                    v_next     = s_tdata[95:64];
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (first_reg) begin
                    res_time_next   = '0;
                    res_level_next  = '0;
                    res_stat_next   = DICS_ST_OK;
                    last_time_next  = t_reg;
                    last_level_next = '0;
                    state_next      = S_OUT;
                end else if (bad) begin
                    res_time_next  = t_reg;
                    res_level_next = last_level_reg;
                    res_stat_next  = DICS_ST_INTERVAL;
                    state_next     = S_OUT;
                end else begin
                    dt_next    = dt_full;
                    state_next = S_MUL1;
                end
            end
            S_MUL1: begin
                if (done_art && done_ven && done_out) begin
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                sn_next    = s_neg;
                den_next   = DICS_UNITY + DICS_DENOM_W'(p_out);
                state_next = S_MUL2;
            end
            S_MUL2: begin
                if (done_dt) begin
                    state_next = S_NUM;
                end
            end
            S_NUM: begin
                num_next   = num_mag;
                nn_next    = num_neg;
                state_next = S_DIVST;
            end
            S_DIVST: begin
                state_next = S_DIV;
            end
            S_DIV: begin
                if (done_div) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                res_time_next   = t_reg;
                res_level_next  = fin_level;
                res_stat_next   = fin_stat;
                last_time_next  = t_reg;
                last_level_next = fin_level;
                state_next      = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_time_next  = res_time_reg;
                    m_level_next = res_level_reg;
                    m_stat_next  = res_stat_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            art_rate_reg   <= DICS_ARTERIAL_RST;
            ven_rate_reg   <= DICS_VENOUS_RST;
            out_rate_reg   <= DICS_OUTFLOW_RST;
            min_int_reg    <= DICS_MIN_INT_RST;
            last_time_reg  <= '0;
            last_level_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            art_rate_reg   <= art_rate_next;
            ven_rate_reg   <= ven_rate_next;
            out_rate_reg   <= out_rate_next;
            min_int_reg    <= min_int_next;
            last_time_reg  <= last_time_next;
            last_level_reg <= last_level_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        first_reg     <= first_next;
        t_reg         <= t_next;
        a_reg         <= a_next;
        v_reg         <= v_next;
        dt_reg        <= dt_next;
        sn_reg        <= sn_next;
        den_reg       <= den_next;
        num_reg       <= num_next;
        nn_reg        <= nn_next;
        res_time_reg  <= res_time_next;
        res_level_reg <= res_level_next;
        res_stat_reg  <= res_stat_next;
        m_time_reg    <= m_time_next;
        m_level_reg   <= m_level_next;
        m_stat_reg    <= m_stat_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_level_reg, m_time_reg};
    assign m_tuser  = m_stat_reg;

endmodule

>>> bench/dual_input_compartment_step_core_test.sv
`timescale 1ns / 1ps
// dual_input_compartment_step_core_test: self-checking bench for the compartment step core
// directed rows then random courses over several rate settings, untyped ones checked against
// a local backward euler predictor; depends on dics_pkg and dual_input_compartment_step_core
module dual_input_compartment_step_core_test;
    import dics_pkg::*;

    localparam int HOLD_CYCLES   = 1500;
    localparam int HOLD_AT       = 100;
    localparam int PHASE_ITEMS   = 140;
    localparam int RANDOM_PHASES = 5;
    localparam int SAT_ROW       = 12;

    typedef struct packed {
        logic        first;
        logic [31:0] stime;
        logic [31:0] art;
        logic [31:0] ven;
    } sample_t;

    typedef struct packed {
        logic [31:0]            rtime;
        logic [31:0]            level;
        logic [DICS_STAT_W-1:0] status;
    } result_t;

    typedef struct packed {
        sample_t smp;
        logic    typed;
        result_t want;
    } stim_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [95:0]            s_tdata;   // sample_time, arterial_level, venous_level
    logic                   s_tuser;   // first_sample
    logic                   m_tvalid;
    logic                   m_tready;
    logic [63:0]            m_tdata;   // result_time, tissue_level
    logic [DICS_STAT_W-1:0] m_tuser;   // status
    logic                   cfg_we;
    logic [DICS_IDX_W-1:0]  cfg_index;
    logic [DICS_WORD_W-1:0] cfg_data;

    dual_input_compartment_step_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of the rate registers and the compartment state
    logic [31:0] ka_rate  = DICS_ARTERIAL_RST;
    logic [31:0] kv_rate  = DICS_VENOUS_RST;
    logic [31:0] ko_rate  = DICS_OUTFLOW_RST;
    logic [15:0] min_step = DICS_MIN_INT_RST;
    logic [31:0] prev_time  = '0;
    logic [31:0] prev_level = '0;

    result_t   expected_results[$];
    stim_row_t stim_rows[$];
    int        mismatches = 0;
    int        results_seen = 0;
    logic [31:0] course_time = '0;
    int        stretch_left[2] = '{0, 0};
    bit        stretch_quiet[2] = '{0, 0};

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic result_t compartment_step(input sample_t smp);
        logic [31:0]         dt;
        logic signed [127:0] cw, aw, vw, kaw, kvw, dtw, num;
        logic [127:0]        mag, den, quo;
        result_t             r;
        r.rtime  = smp.stime;
        r.level  = '0;
        r.status = DICS_ST_OK;
        if (smp.first) begin
            prev_time  = smp.stime;
            prev_level = '0;
            r.rtime    = '0;
            return r;
        end
        dt = smp.stime - prev_time;
        if (smp.stime < prev_time || dt < {16'b0, min_step}) begin
            r.level  = prev_level;
            r.status = DICS_ST_INTERVAL;
            return r;
        end
        cw  = $signed(prev_level);
        aw  = $signed(smp.art);
        vw  = $signed(smp.ven);
        kaw = {96'b0, ka_rate};
        kvw = {96'b0, kv_rate};
        dtw = {96'b0, dt};
        num = (cw <<< DICS_FRAC_SH) + dtw * (kaw * aw + kvw * vw);
        mag = num[127] ? -num : num;
        den = (128'd1 << DICS_FRAC_SH) + {96'b0, ko_rate} * {96'b0, dt};
        quo = ((mag << 1) + den) / (den << 1);
        if (num[127]) begin
            if (quo > 128'h8000_0000) begin
                quo      = 128'h8000_0000;
                r.status = DICS_ST_SAT;
            end
            r.level = ~quo[31:0] + 32'd1;
        end else begin
            if (quo > 128'h7FFF_FFFF) begin
                quo      = 128'h7FFF_FFFF;
                r.status = DICS_ST_SAT;
            end
            r.level = quo[31:0];
        end
        prev_time  = smp.stime;
        prev_level = r.level;
        return r;
    endfunction

    // stretches of back-to-back transactions and stretches with random gaps, chosen at random
    function automatic int draw_wait(input int side);
        if (stretch_left[side] == 0) begin
            stretch_left[side]  = 16;
            stretch_quiet[side] = ($urandom_range(0, 2) == 0);
        end
        stretch_left[side]--;
        return stretch_quiet[side] ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic logic [31:0] random_level();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 6)
            return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
        else if (mode < 8)
            return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // mostly well-formed time courses, with short, backward and wild intervals mixed in
    function automatic sample_t random_sample();
        sample_t smp;
        int      kind;
        kind      = $urandom_range(0, 99);
        smp.first = 1'b0;
        smp.art   = random_level();
        smp.ven   = random_level();
        if (kind < 5) begin
            smp.first   = 1'b1;
            smp.stime   = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h00FF_FFFF);
            course_time = smp.stime;
        end else if (kind < 85) begin
            smp.stime   = course_time + $urandom_range(min_step + 32'h0004_0000, min_step);
            course_time = smp.stime;
        end else if (kind < 92) begin
            smp.stime = course_time + $urandom_range(0, min_step);
        end else if (kind < 96) begin
            smp.stime = course_time - $urandom_range(1, 32'h0010_0000);
        end else begin
            smp.stime   = $urandom;
            course_time = smp.stime;
        end
        return smp;
    endfunction

    function automatic void add_row(input logic first, input logic [31:0] stime,
                                    input logic [31:0] art, input logic [31:0] ven,
                                    input logic typed, input logic [31:0] rtime,
                                    input logic [31:0] level, input logic [1:0] status);
        stim_row_t row;
        row.smp.first   = first;
        row.smp.stime   = stime;
        row.smp.art     = art;
        row.smp.ven     = ven;
        row.typed       = typed;
        row.want.rtime  = rtime;
        row.want.level  = level;
        row.want.status = status;
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t ns", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic write_reg(input logic [DICS_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            DICS_IDX_ARTERIAL: ka_rate  = val;
            DICS_IDX_VENOUS:   kv_rate  = val;
            DICS_IDX_OUTFLOW:  ko_rate  = val;
            DICS_IDX_MIN_INT:  min_step = val[15:0];
            default: ;
        endcase
    endtask

    task automatic write_rates(input logic [31:0] ka, input logic [31:0] kv,
                               input logic [31:0] ko, input logic [31:0] mi);
        write_reg(DICS_IDX_ARTERIAL, ka);
        write_reg(DICS_IDX_VENOUS, kv);
        write_reg(DICS_IDX_OUTFLOW, ko);
        write_reg(DICS_IDX_MIN_INT, mi);
    endtask

    task automatic send_sample(input sample_t smp, input logic typed, input result_t want);
        int      gap;
        result_t pred;
        gap = draw_wait(0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= smp.first;
        s_tdata  <= {smp.ven, smp.art, smp.stime};
        do @(posedge aclk); while (!s_tready);
        pred = compartment_step(smp);
        expected_results.insert(expected_results.size(), typed ? want : pred);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
    endtask

    // sender
    initial begin
        result_t none;
        none      = '0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;

        // reset rates: no series yet, first sample, zero and backward intervals, extremes
        add_row(0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                1, 32'h0000_0000, 32'h0000_0000, DICS_ST_INTERVAL);
        add_row(0, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 0, 0, 0, 0);
        add_row(1, 32'h0010_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                1, 32'h0000_0000, 32'h0000_0000, DICS_ST_OK);
        add_row(0, 32'h0010_0000, 32'h0001_0000, 32'h0001_0000,
                1, 32'h0010_0000, 32'h0000_0000, DICS_ST_INTERVAL);
        add_row(0, 32'h000F_0000, 32'h0001_0000, 32'h0001_0000,
                1, 32'h000F_0000, 32'h0000_0000, DICS_ST_INTERVAL);
        add_row(0, 32'h0010_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0);
        add_row(0, 32'h0012_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0);
        add_row(0, 32'h0014_0000, 32'h0123_4567, 32'hFEDC_BA98, 0, 0, 0, 0);
        add_row(0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0);
        add_row(1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                1, 32'h0000_0000, 32'h0000_0000, DICS_ST_OK);
        add_row(0, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                1, 32'h0000_0000, 32'h0000_0000, DICS_ST_INTERVAL);
        add_row(1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                1, 32'h0000_0000, 32'h0000_0000, DICS_ST_OK);
        // maximal inflow, no outflow, zero interval allowed: saturation both ways
        add_row(1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                1, 32'h0000_0000, 32'h0000_0000, DICS_ST_OK);
        add_row(0, 32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                1, 32'h0000_0000, 32'h0000_0000, DICS_ST_OK);
        add_row(0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                1, 32'h0001_0000, 32'h7FFF_FFFF, DICS_ST_SAT);
        add_row(0, 32'h0001_0000, 32'h8000_0000, 32'h8000_0000,
                1, 32'h0001_0000, 32'h7FFF_FFFF, DICS_ST_OK);
        add_row(0, 32'h0002_0000, 32'h8000_0000, 32'h8000_0000,
                1, 32'h0002_0000, 32'h8000_0000, DICS_ST_SAT);
        add_row(0, 32'h0002_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                1, 32'h0002_0000, 32'h8000_0000, DICS_ST_OK);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < stim_rows.size(); i++) begin
            if (i == SAT_ROW) begin
                drain_results();
                write_rates(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
            end
            send_sample(stim_rows[i].smp, stim_rows[i].typed, stim_rows[i].want);
        end
        drain_results();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: write_rates(DICS_ARTERIAL_RST, DICS_VENOUS_RST, DICS_OUTFLOW_RST,
                               {16'h0000, DICS_MIN_INT_RST});
                1: write_rates($urandom, $urandom, $urandom,
                               $urandom_range(0, 16'hFFFF));
                2: write_rates(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                3: write_rates(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
                default: write_rates($urandom_range(0, 32'h0100_0000),
                                     $urandom_range(0, 32'h0100_0000),
                                     $urandom_range(0, 32'h0100_0000),
                                     $urandom_range(0, 16));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(random_sample(), 1'b0, none);
            drain_results();
        end

        repeat (120) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // receiver
    initial begin
        int      stall;
        result_t want;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = draw_wait(1);
            if (results_seen == HOLD_AT)
                stall = HOLD_CYCLES;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transaction", m_tdata[31:0], 32'h0);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[31:0] !== want.rtime)
                    report_mismatch("result_time", m_tdata[31:0], want.rtime);
                if (m_tdata[63:32] !== want.level)
                    report_mismatch("tissue_level", m_tdata[63:32], want.level);
                if (m_tuser !== want.status)
                    report_mismatch("status", {30'b0, m_tuser}, {30'b0, want.status});
            end
        end
    end

endmodule
